/* design/sact_pkg.sv */
// shared types and constants for the cache tag store
// no dependencies
package sact_pkg;
  localparam int unsigned DefWays    = 4;
  localparam int unsigned DefMaxSets = 256;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned StampW     = 32;
  localparam int unsigned CountW     = 16;
  localparam int unsigned CfgW       = 4;

  localparam logic [1:0] RegMode  = 2'd0;
  localparam logic [1:0] RegBlock = 2'd1;
  localparam logic [1:0] RegSet   = 2'd2;

  localparam logic [1:0] ModeFifo = 2'd0;
  localparam logic [1:0] ModeLru  = 2'd1;
  localparam logic [1:0] ModeLfu  = 2'd2;
  localparam logic [1:0] ModeZero = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  tag;
    logic [StampW-1:0] last_use;
    logic [CountW-1:0] use_count;
    logic [StampW-1:0] fill_time;
  } line_t;
endpackage

/* design/set_assoc_cache_tag_store_top.sv */
// tag store of a set-associative cache with fifo, lru, lfu and fixed way-0 replacement
// depends on sact_pkg and sact_set_ram
//
// channel  | valid        | stall        | payload
// input    | addr_valid_i | addr_stall_o | addr_i
// output   | res_valid_o  | res_stall_i  | hit_o way_used_o hit_total_o miss_total_o
//
// an access reads the set, then compares and writes back
// the input is stalled while an access compares and writes back, so a new access is taken only once the last is done
// after reset a pass clears one set per cycle, all MaxSets sets, with input stalled
// the result sits in an output register; while it is stalled the next input
// transfer is held off
module set_assoc_cache_tag_store_top import sact_pkg::*; #(
  parameter int unsigned Ways    = DefWays,
  parameter int unsigned MaxSets = DefMaxSets
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic              addr_valid_i,
  output logic              addr_stall_o,
  input  logic [AddrW-1:0]  addr_i,
  output logic              res_valid_o,
  input  logic              res_stall_i,
  output logic              hit_o,
  output logic [1:0]        way_used_o,
  output logic [31:0]       hit_total_o,
  output logic [31:0]       miss_total_o
);
  localparam int unsigned SetW = (MaxSets > 1) ? $clog2(MaxSets) : 1;
  localparam int unsigned WayW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam logic [CfgW-1:0] MaxSb = CfgW'($clog2(MaxSets));

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StLook  = 2'd2;

  logic [1:0]      st_q, st_d;
  logic [SetW-1:0] clr_q;
  logic [1:0]      mode_q;
  logic [CfgW-1:0] blk_q, sb_q;
  logic [StampW-1:0] clk_cnt_q;
  logic [31:0]     hits_q, miss_q;
  logic [SetW-1:0] set_q;
  logic [AddrW-1:0] tag_q;

  logic            in_xfer, out_xfer;
  logic [CfgW-1:0] sb_eff;
  logic [AddrW-1:0] sh_addr, set_mask;
  logic [SetW-1:0] set_idx;
  logic [AddrW-1:0] tag_val;

  line_t [Ways-1:0] rd_data, wr_data;
  logic            wr_en;
  logic [SetW-1:0] wr_addr;

  assign sb_eff   = (sb_q > MaxSb) ? MaxSb : sb_q;
  assign sh_addr  = addr_i >> blk_q;
  assign set_mask = (AddrW'(1) << sb_eff) - AddrW'(1);
  assign set_idx  = SetW'(sh_addr & set_mask);
  assign tag_val  = AddrW'({1'b0, addr_i} >> ({1'b0, blk_q} + {1'b0, sb_eff}));

  assign addr_stall_o = (st_q != StIdle) || (res_valid_o && res_stall_i);
  assign in_xfer  = addr_valid_i && !addr_stall_o;
  assign out_xfer = res_valid_o && !res_stall_i;

  sact_set_ram #(.Ways(Ways), .Depth(MaxSets)) u_ram (
    .clk_i,
    .rd_en_i  (in_xfer),
    .rd_addr_i(set_idx),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // lookup and victim choice
  logic [StampW-1:0] stamp;
  logic             hit;
  logic [WayW-1:0]  hit_way, inv_way, key_way, vic_way, way;
  logic             any_inv;
  logic [StampW-1:0] best, key;

  assign stamp = (clk_cnt_q == '1) ? clk_cnt_q : clk_cnt_q + 1'b1;

  always_comb begin
    hit = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (rd_data[w].valid && rd_data[w].tag == tag_q) begin
        hit = 1'b1;
        hit_way = WayW'(w);
      end
      if (!rd_data[w].valid) begin
        any_inv = 1'b1;
        inv_way = WayW'(w);
      end
    end
  end

  always_comb begin
    best = '0;
    key_way = '0;
    for (int w = 0; w < Ways; w++) begin
      unique case (mode_q)
        ModeFifo: key = rd_data[w].fill_time;
        ModeLru:  key = rd_data[w].last_use;
        default:  key = StampW'(rd_data[w].use_count);
      endcase
      if (w == 0 || key < best) begin
        best = key;
        key_way = WayW'(w);
      end
    end
  end

  always_comb begin
    if (mode_q == ModeZero) begin
      vic_way = '0;
    end else if (any_inv) begin
      vic_way = inv_way;
    end else begin
      vic_way = key_way;
    end
    way = hit ? hit_way : vic_way;
  end

  always_comb begin
    wr_data = rd_data;
    wr_en   = 1'b0;
    wr_addr = set_q;
    if (st_q == StClear) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else if (st_q == StLook) begin
      wr_en = 1'b1;
      if (hit) begin
        wr_data[hit_way].last_use = stamp;
        if (rd_data[hit_way].use_count != '1) begin
          wr_data[hit_way].use_count = rd_data[hit_way].use_count + 1'b1;
        end
      end else begin
        wr_data[vic_way].valid     = 1'b1;
        wr_data[vic_way].tag       = tag_q;
        wr_data[vic_way].last_use  = stamp;
        wr_data[vic_way].use_count = CountW'(1);
        wr_data[vic_way].fill_time = stamp;
      end
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StClear: if (clr_q == SetW'(MaxSets - 1)) st_d = StIdle;
      StIdle:  if (in_xfer) st_d = StLook;
      StLook:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StClear;
      clr_q       <= '0;
      mode_q      <= ModeLru;
      blk_q       <= CfgW'(6);
      sb_q        <= CfgW'(8);
      clk_cnt_q   <= '0;
      hits_q      <= '0;
      miss_q      <= '0;
      res_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StClear) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegMode:  mode_q <= cfg_data_i[1:0];
          RegBlock: blk_q  <= cfg_data_i;
          RegSet:   sb_q   <= cfg_data_i;
          default:  ;
        endcase
      end
      if (st_q == StLook) begin
        clk_cnt_q   <= stamp;
        res_valid_o <= 1'b1;
        if (hit) begin
          if (hits_q != '1) hits_q <= hits_q + 1'b1;
        end else begin
          if (miss_q != '1) miss_q <= miss_q + 1'b1;
        end
      end else if (out_xfer) begin
        res_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      set_q <= set_idx;
      tag_q <= tag_val;
    end
    if (st_q == StLook) begin
      hit_o      <= hit;
      way_used_o <= 2'(way);
      hit_total_o  <= (hit && hits_q != '1) ? hits_q + 1'b1 : hits_q;
      miss_total_o <= (!hit && miss_q != '1) ? miss_q + 1'b1 : miss_q;
    end
  end

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StClear |-> !in_xfer) else $error("transfer during clearing pass");
  a_look_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> st_q == StLook) else $error("lookup did not follow transfer");
  a_result_after_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StLook |=> res_valid_o) else $error("no result after lookup");
  a_totals_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StLook && hits_q != '1 && miss_q != '1 |=>
    hits_q + miss_q == $past(hits_q) + $past(miss_q) + 1) else $error("count slip");
`endif
endmodule

/* design/sact_set_ram.sv */
// one set of lines per entry, synchronous read, one write port
// depends on sact_pkg
module sact_set_ram import sact_pkg::*; #(
  parameter int unsigned Ways  = DefWays,
  parameter int unsigned Depth = DefMaxSets
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output line_t [Ways-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  line_t [Ways-1:0]         wr_data_i
);
  line_t [Ways-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end
endmodule
